### design/rgbcvt_pkg.sv
// Shared types, constants and packing functions for the RGB to 16bpp converter.
// No dependencies; used by every module of the block except rgbcvt_ram.
`timescale 1ns / 1ps
`default_nettype none

package rgbcvt_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int IDX_W         = 8;
    localparam int ENTRY_W       = 24;
    localparam int PIXEL_W       = 16;
    localparam int SKIP_IN_W     = 24;
    localparam int SKIP_W        = 25;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;

    // floor(x/3) == (x * RECIP) >> SHIFT for every x below 2**25
    localparam int              DIV3_SHIFT = 26;
    localparam logic [SKIP_W:0] DIV3_RECIP = 26'h1555556;
    localparam int              PROD_W     = SKIP_W + DIV3_SHIFT + 1;

    localparam logic [7:0] RUN_FILL  = 8'd5;
    localparam logic [7:0] MASK_BASE = 8'h7F;

    typedef enum logic [2:0] {
        ACT_RAW    = 3'd0,
        ACT_RUN    = 3'd1,
        ACT_PAL    = 3'd2,
        ACT_LOAD   = 3'd3,
        ACT_SKIP24 = 3'd4,
        ACT_SKIP8  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        REG_RED_LOSS   = 3'd0,
        REG_RED_POS    = 3'd1,
        REG_GREEN_LOSS = 3'd2,
        REG_GREEN_POS  = 3'd3,
        REG_BLUE_LOSS  = 3'd4,
        REG_BLUE_POS   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] red_loss;
        logic [3:0] red_pos;
        logic [2:0] green_loss;
        logic [3:0] green_pos;
        logic [2:0] blue_loss;
        logic [3:0] blue_pos;
    } cfg_t;

    function automatic logic [PIXEL_W-1:0] place(input logic [7:0] ch,
                                                 input logic [2:0] loss,
                                                 input logic [3:0] pos);
        logic [PIXEL_W-1:0] t;
        t = {8'h00, ch >> loss};
        return t << pos;
    endfunction

    function automatic logic [PIXEL_W-1:0] pack(input cfg_t cfg,
                                                input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b);
        return place(r, cfg.red_loss, cfg.red_pos)
             | place(g, cfg.green_loss, cfg.green_pos)
             | place(b, cfg.blue_loss, cfg.blue_pos);
    endfunction

    // 0x7F >> loss is the all-ones field of (7 - loss) bits
    function automatic logic [PIXEL_W-1:0] dark_mask(input cfg_t cfg);
        return place(MASK_BASE, cfg.red_loss, cfg.red_pos)
             | place(MASK_BASE, cfg.green_loss, cfg.green_pos)
             | place(MASK_BASE, cfg.blue_loss, cfg.blue_pos);
    endfunction

endpackage

`default_nettype wire

### design/rgbcvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgbcvt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/rgbcvt_regs.sv
// APB configuration registers: channel losses and field positions.
// Depends on rgbcvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbcvt_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rgbcvt_pkg::APB_AW-1:0]     paddr,
    input  wire logic [rgbcvt_pkg::APB_DW-1:0]     pwdata,
    output logic      [rgbcvt_pkg::APB_DW-1:0]     prdata,
    output logic                                   pready,
    output rgbcvt_pkg::cfg_t                       cfg
);

    rgbcvt_pkg::cfg_t cfg_reg;
    rgbcvt_pkg::cfg_t cfg_next;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (rgbcvt_pkg::reg_idx_t'(reg_idx))
                rgbcvt_pkg::REG_RED_LOSS:   cfg_next.red_loss   = pwdata[2:0];
                rgbcvt_pkg::REG_RED_POS:    cfg_next.red_pos    = pwdata[3:0];
                rgbcvt_pkg::REG_GREEN_LOSS: cfg_next.green_loss = pwdata[2:0];
                rgbcvt_pkg::REG_GREEN_POS:  cfg_next.green_pos  = pwdata[3:0];
                rgbcvt_pkg::REG_BLUE_LOSS:  cfg_next.blue_loss  = pwdata[2:0];
                rgbcvt_pkg::REG_BLUE_POS:   cfg_next.blue_pos   = pwdata[3:0];
                default:                    cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (rgbcvt_pkg::reg_idx_t'(reg_idx))
            rgbcvt_pkg::REG_RED_LOSS:   prdata = 32'(cfg_reg.red_loss);
            rgbcvt_pkg::REG_RED_POS:    prdata = 32'(cfg_reg.red_pos);
            rgbcvt_pkg::REG_GREEN_LOSS: prdata = 32'(cfg_reg.green_loss);
            rgbcvt_pkg::REG_GREEN_POS:  prdata = 32'(cfg_reg.green_pos);
            rgbcvt_pkg::REG_BLUE_LOSS:  prdata = 32'(cfg_reg.blue_loss);
            rgbcvt_pkg::REG_BLUE_POS:   prdata = 32'(cfg_reg.blue_pos);
            default:                    prdata = '0;
        endcase
    end

    // reset format is RGB565
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_loss   <= 3'd3;
            cfg_reg.red_pos    <= 4'd11;
            cfg_reg.green_loss <= 3'd2;
            cfg_reg.green_pos  <= 4'd5;
            cfg_reg.blue_loss  <= 3'd3;
            cfg_reg.blue_pos   <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/rgbcvt_palette.sv
// Palette store: RAM plus per-entry valid bits, so unwritten entries read as zero.
// Depends on rgbcvt_pkg and rgbcvt_ram.
`timescale 1ns / 1ps
`default_nettype none

module rgbcvt_palette (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [rgbcvt_pkg::IDX_W-1:0]       wr_idx,
    input  wire logic [rgbcvt_pkg::ENTRY_W-1:0]     wr_data,
    input  wire logic                               rd_en,
    input  wire logic [rgbcvt_pkg::IDX_W-1:0]       rd_idx,
    output logic      [rgbcvt_pkg::ENTRY_W-1:0]     rd_data
);

    localparam logic [rgbcvt_pkg::IDX_W:0] IDX_LIMIT =
        (rgbcvt_pkg::IDX_W + 1)'(rgbcvt_pkg::PALETTE_DEPTH);

    logic [rgbcvt_pkg::PALETTE_DEPTH-1:0] valid_reg;
    logic [rgbcvt_pkg::PALETTE_DEPTH-1:0] valid_next;
    logic                                 hit_reg;
    logic                                 hit_next;
    logic [rgbcvt_pkg::PAL_AW-1:0]        wr_addr;
    logic [rgbcvt_pkg::PAL_AW-1:0]        rd_addr;
    logic                                 wr_in_range;
    logic                                 rd_in_range;
    logic                                 ram_we;
    logic [rgbcvt_pkg::ENTRY_W-1:0]       ram_q;

    assign wr_addr     = wr_idx[rgbcvt_pkg::PAL_AW-1:0];
    assign rd_addr     = rd_idx[rgbcvt_pkg::PAL_AW-1:0];
    assign wr_in_range = {1'b0, wr_idx} < IDX_LIMIT;
    assign rd_in_range = {1'b0, rd_idx} < IDX_LIMIT;
    assign ram_we      = wr_en && wr_in_range;

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    // hit is sampled with the read so it lines up with the registered RAM data
    assign hit_next = rd_en ? (rd_in_range && valid_reg[rd_addr]) : hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    rgbcvt_ram #(
        .WIDTH (rgbcvt_pkg::ENTRY_W),
        .DEPTH (rgbcvt_pkg::PALETTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign rd_data = hit_reg ? ram_q : '0;

endmodule

`default_nettype wire

### design/rgbcvt_pack.sv
// Pixel packing datapath: shift/place, run-fill substitution and dark step.
// Depends on rgbcvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbcvt_pack (
    input  wire rgbcvt_pkg::cfg_t                   cfg,
    input  wire logic [7:0]                         red,
    input  wire logic [7:0]                         green,
    input  wire logic [7:0]                         blue,
    input  wire logic                               run_fill,
    input  wire logic                               darken,
    output logic      [rgbcvt_pkg::PIXEL_W-1:0]     pixel
);

    logic [rgbcvt_pkg::PIXEL_W-1:0] packed_px;
    logic [rgbcvt_pkg::PIXEL_W-1:0] fill_px;
    logic [rgbcvt_pkg::PIXEL_W-1:0] base_px;

    assign packed_px = rgbcvt_pkg::pack(cfg, red, green, blue);
    assign fill_px   = rgbcvt_pkg::pack(cfg, rgbcvt_pkg::RUN_FILL, rgbcvt_pkg::RUN_FILL,
                                        rgbcvt_pkg::RUN_FILL);

    // a run pixel that packs to zero would read as transparent
    assign base_px = (run_fill && packed_px == '0) ? fill_px : packed_px;

    assign pixel = darken ? ((base_px >> 1) & rgbcvt_pkg::dark_mask(cfg)) : base_px;

endmodule

`default_nettype wire

### design/rgb_palette_to_16bpp_pixel_converter.sv
// Top level: RGB / palette pixels to configurable 16bpp words, plus run-skip rescale.
// Words pass the stage-1 register (with the registered palette RAM read), then the result
// register; one word per cycle sustained while out_ready stays high.
// Words that give no result (palette load, unused codes) leave after the accept cycle.
// Reset: format registers return to RGB565, palette valid bits clear at once
// (every entry reads zero), pipeline empties. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_palette_to_16bpp_pixel_converter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rgbcvt_pkg::APB_AW-1:0]      paddr,
    input  wire logic [rgbcvt_pkg::APB_DW-1:0]      pwdata,
    output logic      [rgbcvt_pkg::APB_DW-1:0]      prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [2:0]                         action,
    input  wire logic [7:0]                         red,
    input  wire logic [7:0]                         green,
    input  wire logic [7:0]                         blue,
    input  wire logic [rgbcvt_pkg::IDX_W-1:0]       color_index,
    input  wire logic                               darken,
    input  wire logic [rgbcvt_pkg::SKIP_IN_W-1:0]   skip_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [rgbcvt_pkg::PIXEL_W-1:0]     pixel_out,
    output logic      [rgbcvt_pkg::SKIP_W-1:0]      skip_out
);

    rgbcvt_pkg::cfg_t cfg;

    logic in_accept;
    logic in_has_result;
    logic out_free;
    logic s1_advance;

    // stage 1: captured word, palette read in flight
    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    rgbcvt_pkg::action_t                   s1_action_reg;
    rgbcvt_pkg::action_t                   s1_action_next;
    logic [7:0]                            s1_red_reg;
    logic [7:0]                            s1_red_next;
    logic [7:0]                            s1_green_reg;
    logic [7:0]                            s1_green_next;
    logic [7:0]                            s1_blue_reg;
    logic [7:0]                            s1_blue_next;
    logic                                  s1_darken_reg;
    logic                                  s1_darken_next;
    logic [rgbcvt_pkg::SKIP_IN_W-1:0]      s1_skip_reg;
    logic [rgbcvt_pkg::SKIP_IN_W-1:0]      s1_skip_next;

    // result register
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [rgbcvt_pkg::PIXEL_W-1:0]        pixel_reg;
    logic [rgbcvt_pkg::PIXEL_W-1:0]        pixel_next;
    logic [rgbcvt_pkg::SKIP_W-1:0]         skip_reg;
    logic [rgbcvt_pkg::SKIP_W-1:0]         skip_next;

    logic [rgbcvt_pkg::ENTRY_W-1:0]        pal_entry;
    logic [7:0]                            ch_red;
    logic [7:0]                            ch_green;
    logic [7:0]                            ch_blue;
    logic                                  run_fill;
    logic [rgbcvt_pkg::PIXEL_W-1:0]        packed_pixel;
    logic [rgbcvt_pkg::SKIP_W-1:0]         skip_x2;
    logic [rgbcvt_pkg::PROD_W-1:0]         skip_prod;
    logic [rgbcvt_pkg::SKIP_W-1:0]         skip_div3;

    rgbcvt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        case (rgbcvt_pkg::action_t'(action))
            rgbcvt_pkg::ACT_RAW,
            rgbcvt_pkg::ACT_RUN,
            rgbcvt_pkg::ACT_PAL,
            rgbcvt_pkg::ACT_SKIP24,
            rgbcvt_pkg::ACT_SKIP8:  in_has_result = 1'b1;
            default:                in_has_result = 1'b0;
        endcase
    end

    rgbcvt_palette u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept && rgbcvt_pkg::action_t'(action) == rgbcvt_pkg::ACT_LOAD),
        .wr_idx  (color_index),
        .wr_data ({red, green, blue}),
        .rd_en   (in_accept && rgbcvt_pkg::action_t'(action) == rgbcvt_pkg::ACT_PAL),
        .rd_idx  (color_index),
        .rd_data (pal_entry)
    );

    // only words with a result enter stage 1
    always_comb
    begin
        s1_action_next = s1_action_reg;
        s1_red_next    = s1_red_reg;
        s1_green_next  = s1_green_reg;
        s1_blue_next   = s1_blue_reg;
        s1_darken_next = s1_darken_reg;
        s1_skip_next   = s1_skip_reg;
        if (in_accept)
        begin
            s1_valid_next  = in_has_result;
            s1_action_next = rgbcvt_pkg::action_t'(action);
            s1_red_next    = red;
            s1_green_next  = green;
            s1_blue_next   = blue;
            s1_darken_next = darken;
            s1_skip_next   = skip_in;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_action_reg == rgbcvt_pkg::ACT_PAL)
        begin
            ch_red   = pal_entry[23:16];
            ch_green = pal_entry[15:8];
            ch_blue  = pal_entry[7:0];
        end
        else
        begin
            ch_red   = s1_red_reg;
            ch_green = s1_green_reg;
            ch_blue  = s1_blue_reg;
        end
    end

    assign run_fill = (s1_action_reg == rgbcvt_pkg::ACT_RUN);

    rgbcvt_pack u_pack (
        .cfg      (cfg),
        .red      (ch_red),
        .green    (ch_green),
        .blue     (ch_blue),
        .run_fill (run_fill),
        .darken   (s1_darken_reg),
        .pixel    (packed_pixel)
    );

    // divide by 3 through the reciprocal; exact for all 25-bit doubled skips
    assign skip_x2   = {s1_skip_reg, 1'b0};
    assign skip_prod = rgbcvt_pkg::PROD_W'(skip_x2) * rgbcvt_pkg::PROD_W'(rgbcvt_pkg::DIV3_RECIP);
    assign skip_div3 = skip_prod[rgbcvt_pkg::DIV3_SHIFT +: rgbcvt_pkg::SKIP_W];

    always_comb
    begin
        pixel_next = pixel_reg;
        skip_next  = skip_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
            case (s1_action_reg)
                rgbcvt_pkg::ACT_SKIP24:
                begin
                    pixel_next = '0;
                    skip_next  = skip_div3;
                end
                rgbcvt_pkg::ACT_SKIP8:
                begin
                    pixel_next = '0;
                    skip_next  = skip_x2;
                end
                default:
                begin
                    pixel_next = packed_pixel;
                    skip_next  = '0;
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_action_reg <= s1_action_next;
        s1_red_reg    <= s1_red_next;
        s1_green_reg  <= s1_green_next;
        s1_blue_reg   <= s1_blue_next;
        s1_darken_reg <= s1_darken_next;
        s1_skip_reg   <= s1_skip_next;
        pixel_reg     <= pixel_next;
        skip_reg      <= skip_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign skip_out  = skip_reg;

endmodule

`default_nettype wire

### design/rgbcvt_checker.sv
// Port-level checker for the pixel converter, bound to the top level.
// Depends on rgbcvt_pkg and rgb_palette_to_16bpp_pixel_converter.
`timescale 1ns / 1ps
`default_nettype none

module rgbcvt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [2:0]                         action,
    input  wire logic [rgbcvt_pkg::SKIP_IN_W-1:0]   skip_in,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [rgbcvt_pkg::PIXEL_W-1:0]     pixel_out,
    input  wire logic [rgbcvt_pkg::SKIP_W-1:0]      skip_out
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(skip_out))
        else $error("result word changed while stalled");

    // the input side only stalls behind a stalled full result register
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output could drain");

    // pixel and skip results never both carry data
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out == '0 || skip_out == '0))
        else $error("pixel and skip both nonzero");

    // an 8bpp skip with a free output path comes out doubled through stage 1 and the result register
    a_skip8: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == rgbcvt_pkg::ACT_SKIP8 && out_ready ##1 out_ready
        |=> out_valid && skip_out == {$past(skip_in, 2), 1'b0} && pixel_out == '0)
        else $error("skip8 result wrong or late");

endmodule

bind rgb_palette_to_16bpp_pixel_converter rgbcvt_checker u_checker (.*);

`default_nettype wire

### test/rgb_palette_to_16bpp_pixel_converter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGB / palette to 16bpp pixel converter.
// Directed and random words against a local predictor of packing, palette and skip scaling.
// Depends on rgbcvt_pkg and rgb_palette_to_16bpp_pixel_converter.
module rgb_palette_to_16bpp_pixel_converter_test;

    // codes the block ignores
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 106;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [2:0]                       act;
        logic [7:0]                       r;
        logic [7:0]                       g;
        logic [7:0]                       b;
        logic [rgbcvt_pkg::IDX_W-1:0]     idx;
        logic                             dk;
        logic [rgbcvt_pkg::SKIP_IN_W-1:0] skip;
    } conv_word_t;

    typedef struct {
        logic [rgbcvt_pkg::PIXEL_W-1:0] pixel;
        logic [rgbcvt_pkg::SKIP_W-1:0]  skip;
    } conv_result_t;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [rgbcvt_pkg::APB_AW-1:0]      paddr       = '0;
    logic [rgbcvt_pkg::APB_DW-1:0]      pwdata      = '0;
    logic [rgbcvt_pkg::APB_DW-1:0]      prdata;
    logic                               pready;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic [2:0]                         action      = rgbcvt_pkg::ACT_RAW;
    logic [7:0]                         red         = '0;
    logic [7:0]                         green       = '0;
    logic [7:0]                         blue        = '0;
    logic [rgbcvt_pkg::IDX_W-1:0]       color_index = '0;
    logic                               darken      = 1'b0;
    logic [rgbcvt_pkg::SKIP_IN_W-1:0]   skip_in     = '0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [rgbcvt_pkg::PIXEL_W-1:0]     pixel_out;
    logic [rgbcvt_pkg::SKIP_W-1:0]      skip_out;

    // format copy, reset values are RGB565
    logic [2:0] fmt_red_loss   = 3'd3;
    logic [3:0] fmt_red_pos    = 4'd11;
    logic [2:0] fmt_green_loss = 3'd2;
    logic [3:0] fmt_green_pos  = 4'd5;
    logic [2:0] fmt_blue_loss  = 3'd3;
    logic [3:0] fmt_blue_pos   = 4'd0;

    logic [rgbcvt_pkg::ENTRY_W-1:0] palette_copy [rgbcvt_pkg::PALETTE_DEPTH];
    conv_word_t                     words_to_send [$];
    conv_result_t                   conv_expected [$];

    int   idle_in_pct   = 0;
    int   stall_out_pct = 0;
    int   words_pushed  = 0;
    int   words_taken   = 0;
    int   errors        = 0;
    int   cycles        = 0;
    logic in_taken      = 1'b0;

    rgb_palette_to_16bpp_pixel_converter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .color_index (color_index),
        .darken      (darken),
        .skip_in     (skip_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .skip_out    (skip_out)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] field_of(input logic [7:0] ch, input logic [2:0] loss,
                                             input logic [3:0] pos);
        logic [31:0] wide;
        wide = {24'd0, ch} >> loss;
        return 16'(wide << pos);
    endfunction

    function automatic logic [15:0] packed_rgb(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return field_of(r, fmt_red_loss, fmt_red_pos)
             | field_of(g, fmt_green_loss, fmt_green_pos)
             | field_of(b, fmt_blue_loss, fmt_blue_pos);
    endfunction

    function automatic logic [15:0] mask_field(input logic [2:0] loss, input logic [3:0] pos);
        logic [31:0] ones;
        ones = (32'd1 << (3'd7 - loss)) - 32'd1;
        return 16'(ones << pos);
    endfunction

    // apply the accepted word to the palette copy and queue what it should produce
    function automatic void predict_word(input conv_word_t w);
        conv_result_t res;
        logic [15:0]  px;
        logic [23:0]  e;
        logic [31:0]  twice;
        logic         gives_pixel;
        res.pixel   = '0;
        res.skip    = '0;
        px          = '0;
        gives_pixel = 1'b0;
        twice       = {8'd0, w.skip} << 1;
        case (w.act)
            rgbcvt_pkg::ACT_RAW:
            begin
                px          = packed_rgb(w.r, w.g, w.b);
                gives_pixel = 1'b1;
            end
            rgbcvt_pkg::ACT_RUN:
            begin
                px = packed_rgb(w.r, w.g, w.b);
                if (px == 16'd0)
                    px = packed_rgb(8'd5, 8'd5, 8'd5);
                gives_pixel = 1'b1;
            end
            rgbcvt_pkg::ACT_PAL:
            begin
                e           = palette_copy[w.idx];
                px          = packed_rgb(e[23:16], e[15:8], e[7:0]);
                gives_pixel = 1'b1;
            end
            rgbcvt_pkg::ACT_LOAD:
                palette_copy[w.idx] = {w.r, w.g, w.b};
            rgbcvt_pkg::ACT_SKIP24:
            begin
                res.skip = 25'(twice / 32'd3);
                conv_expected.push_back(res);
            end
            rgbcvt_pkg::ACT_SKIP8:
            begin
                res.skip = 25'(twice);
                conv_expected.push_back(res);
            end
            default:
                ;
        endcase
        if (gives_pixel)
        begin
            if (w.dk)
                px = (px >> 1) & (mask_field(fmt_red_loss, fmt_red_pos)
                                | mask_field(fmt_green_loss, fmt_green_pos)
                                | mask_field(fmt_blue_loss, fmt_blue_pos));
            res.pixel = px;
            conv_expected.push_back(res);
        end
    endfunction

    function automatic void report_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    // accept side and result checking, sampled at the rising edge
    always @(posedge clk)
    begin : sample
        conv_word_t   w;
        conv_result_t want;
        if (rst_n)
        begin
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("rgb_palette_to_16bpp_pixel_converter_test: errors");
                $finish;
            end
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                w.act  = action;
                w.r    = red;
                w.g    = green;
                w.b    = blue;
                w.idx  = color_index;
                w.dk   = darken;
                w.skip = skip_in;
                predict_word(w);
                words_taken = words_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                if (conv_expected.size() == 0)
                    report_error($sformatf("unexpected word pixel=%h skip=%h",
                                           pixel_out, skip_out));
                else
                begin
                    want = conv_expected.pop_front();
                    if (pixel_out !== want.pixel || skip_out !== want.skip)
                        report_error($sformatf("pixel exp %h got %h, skip exp %h got %h",
                                               want.pixel, pixel_out, want.skip, skip_out));
                end
            end
        end
    end

    // input side changes on the falling edge
    always @(negedge clk)
    begin : drive
        conv_word_t w;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    w = words_to_send.pop_front();
                    in_valid    <= 1'b1;
                    action      <= w.act;
                    red         <= w.r;
                    green       <= w.g;
                    blue        <= w.b;
                    color_index <= w.idx;
                    darken      <= w.dk;
                    skip_in     <= w.skip;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= stall_out_pct);
        end
    end

    function automatic conv_word_t word_of(input logic [2:0] act, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] idx, input logic dk,
                                           input logic [23:0] skip);
        conv_word_t w;
        w.act  = act;
        w.r    = r;
        w.g    = g;
        w.b    = b;
        w.idx  = idx;
        w.dk   = dk;
        w.skip = skip;
        return w;
    endfunction

    function automatic conv_word_t random_word();
        conv_word_t w;
        int         pick;
        pick   = int'($urandom_range(99));
        w      = word_of(rgbcvt_pkg::ACT_RAW, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom_range(1)), 24'($urandom));
        if (pick < 25)
            w.act = rgbcvt_pkg::ACT_RAW;
        else if (pick < 40)
        begin
            w.act = rgbcvt_pkg::ACT_RUN;
            // half of the run pixels pack to zero and take the fill color
            if ($urandom_range(1))
            begin
                w.r = 8'($urandom_range((1 << fmt_red_loss) - 1));
                w.g = 8'($urandom_range((1 << fmt_green_loss) - 1));
                w.b = 8'($urandom_range((1 << fmt_blue_loss) - 1));
            end
        end
        else if (pick < 60)
        begin
            w.act = rgbcvt_pkg::ACT_PAL;
            if ($urandom_range(1))
                w.idx = 8'($urandom_range(15));
        end
        else if (pick < 75)
        begin
            w.act = rgbcvt_pkg::ACT_LOAD;
            if ($urandom_range(1))
                w.idx = 8'($urandom_range(15));
        end
        else if (pick < 86)
            w.act = rgbcvt_pkg::ACT_SKIP24;
        else if (pick < 97)
            w.act = rgbcvt_pkg::ACT_SKIP8;
        else
            w.act = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
        if ($urandom_range(9) == 0)
            w.skip = 24'hFFFFFF - 24'($urandom_range(3));
        return w;
    endfunction

    task automatic push_word(input conv_word_t w);
        words_to_send.push_back(w);
        words_pushed++;
    endtask

    task automatic apb_write(input rgbcvt_pkg::reg_idx_t idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rgbcvt_pkg::APB_AW'(4 * int'(idx));
        pwdata  <= rgbcvt_pkg::APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_format(input int rl, input int rp, input int gl, input int gp,
                              input int bl, input int bp);
        apb_write(rgbcvt_pkg::REG_RED_LOSS, rl);
        apb_write(rgbcvt_pkg::REG_RED_POS, rp);
        apb_write(rgbcvt_pkg::REG_GREEN_LOSS, gl);
        apb_write(rgbcvt_pkg::REG_GREEN_POS, gp);
        apb_write(rgbcvt_pkg::REG_BLUE_LOSS, bl);
        apb_write(rgbcvt_pkg::REG_BLUE_POS, bp);
        fmt_red_loss   = 3'(rl);
        fmt_red_pos    = 4'(rp);
        fmt_green_loss = 3'(gl);
        fmt_green_pos  = 4'(gp);
        fmt_blue_loss  = 3'(bl);
        fmt_blue_pos   = 4'(bp);
    endtask

    // all words taken, all results back, then room for a trailing palette load
    task automatic wait_idle();
        while (words_taken != words_pushed || conv_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int ph;
        int n;
        for (n = 0; n < rgbcvt_pkg::PALETTE_DEPTH; n++)
            palette_copy[n] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words at the reset format
        push_word(word_of(rgbcvt_pkg::ACT_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_RAW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0,
                          24'hFFFFFF));
        push_word(word_of(rgbcvt_pkg::ACT_RAW, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_RAW, 8'hAA, 8'h55, 8'hAA, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_RUN, 8'h07, 8'h03, 8'h07, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_RUN, 8'h08, 8'h04, 8'h08, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'd200, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_LOAD, 8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_LOAD, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP24, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP24, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h1));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP24, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h3));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP24, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                          24'hFFFFFF));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP8, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0));
        push_word(word_of(rgbcvt_pkg::ACT_SKIP8, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                          24'hFFFFFF));
        push_word(word_of(ACT_SPARE6, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1, 24'hFFFFFF));
        push_word(word_of(ACT_SPARE7, 8'h5A, 8'hA5, 8'h5A, 8'h02, 1'b0, 24'h123456));
        push_word(word_of(rgbcvt_pkg::ACT_RAW, 8'h80, 8'h01, 8'hFE, 8'h00, 1'b1, 24'h0));
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_format(3, 11, 2, 5, 3, 0);
                1: set_format(0, 0, 0, 0, 0, 0);
                2: set_format(7, 15, 7, 15, 7, 15);
                3: set_format(3, 0, 2, 5, 3, 11);
                4: set_format(0, 8, 0, 4, 0, 0);
                default: set_format($urandom_range(7), $urandom_range(15), $urandom_range(7),
                                    $urandom_range(15), $urandom_range(7), $urandom_range(15));
            endcase
            case (ph % 4)
                0:
                begin
                    idle_in_pct   = 0;
                    stall_out_pct = 0;
                end
                1:
                begin
                    idle_in_pct   = 82;
                    stall_out_pct = 0;
                end
                2:
                begin
                    idle_in_pct   = 0;
                    stall_out_pct = 82;
                end
                default:
                begin
                    idle_in_pct   = 6;
                    stall_out_pct = 6;
                end
            endcase
            for (n = 0; n < WORDS_PER_PHASE; n++)
                push_word(random_word());
            wait_idle();
        end

        if (errors == 0)
            $display("rgb_palette_to_16bpp_pixel_converter_test: clean");
        else
            $display("rgb_palette_to_16bpp_pixel_converter_test: errors");
        $finish;
    end

endmodule

### rgb_palette_to_16bpp_pixel_converter.f
design/rgbcvt_pkg.sv
design/rgbcvt_ram.sv
design/rgbcvt_regs.sv
design/rgbcvt_palette.sv
design/rgbcvt_pack.sv
design/rgb_palette_to_16bpp_pixel_converter.sv
design/rgbcvt_checker.sv
test/rgb_palette_to_16bpp_pixel_converter_test.sv
